// ----- rtl/dsq_pkg.sv -----
// Shared constants, command codes and item types for the d-separation query block.
`default_nettype none

package dsq_pkg;

  localparam int unsigned DSQ_MAX_NODES  = 16;
  localparam int unsigned DSQ_CMD_DEPTH  = 2;
  localparam int unsigned DSQ_RES_DEPTH  = 2;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned NODE_W = 5;
  localparam int unsigned SET_W  = 16;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [NODE_W-1:0] NUM_NODES_RESET = 5'd16;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ADD,
    OP_REMOVE,
    OP_QUERY,
    OP_CLEAR
  } dsq_op_e;

  // classified command as it travels from front end to engine
  typedef struct packed {
    dsq_op_e           op;
    logic [NODE_W-1:0] count;
  } dsq_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/dag_d_separation_query.sv -----
// Top level of the d-separation query block: config register, queues, front end and engine.
`default_nettype none

// Holds a directed graph of up to MAX_NODES nodes as an edge matrix and answers
// d-separation queries on it. Commands enter a short command queue and results
// leave through a result queue, so both sides may stall freely; one result beat
// comes out for every command, in order. The engine takes one command at a time:
// an edge add, remove, clear or ignored edit goes straight to the result; a query
// runs Pc closure sweeps, until both ancestor closures settle (at least 1, at
// most n), then Pb Bayes-ball sweeps, until the visited sets settle (at least 1,
// at most 2n), where n is the node count in use; the engine visits one node per
// cycle of each sweep. num_nodes may be written only while no command is in
// flight.
module dag_d_separation_query
  import dsq_pkg::*;
#(
  parameter int unsigned MAX_NODES = DSQ_MAX_NODES,
  parameter int unsigned CMD_DEPTH = DSQ_CMD_DEPTH,
  parameter int unsigned RES_DEPTH = DSQ_RES_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic [NODE_W-1:0] from_node_i,
  input  wire logic [NODE_W-1:0] to_node_i,
  input  wire logic [SET_W-1:0]  set_x_i,
  input  wire logic [SET_W-1:0]  set_y_i,
  input  wire logic [SET_W-1:0]  set_z_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   separated_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [NODE_W-1:0] cfg_data_i
);

  localparam int unsigned NW    = MAX_NODES;
  localparam int unsigned IW    = $clog2(MAX_NODES);
  localparam int unsigned ITEM_W = $bits(dsq_ctrl_t) + 2 * IW + 4 * NW;

  logic [NODE_W-1:0] num_nodes_q;

  dsq_ctrl_t         f_ctrl, q_ctrl;
  logic [IW-1:0]     f_from, f_to, q_from, q_to;
  logic [NW-1:0]     f_mask, f_x, f_y, f_z, q_mask, q_x, q_y, q_z;
  logic [ITEM_W-1:0] item_wr, item_rd;
  logic              cmd_empty, cmd_pop;
  logic              res_full, res_push, res_bit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_nodes_q <= NUM_NODES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      num_nodes_q <= cfg_data_i;
    end
  end

  dsq_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .command_i   (command_i),
    .from_node_i (from_node_i),
    .to_node_i   (to_node_i),
    .set_x_i     (set_x_i),
    .set_y_i     (set_y_i),
    .set_z_i     (set_z_i),
    .num_nodes_i (num_nodes_q),
    .ctrl_o      (f_ctrl),
    .from_idx_o  (f_from),
    .to_idx_o    (f_to),
    .mask_o      (f_mask),
    .set_x_o     (f_x),
    .set_y_o     (f_y),
    .set_z_o     (f_z)
  );

  assign item_wr = {f_ctrl, f_from, f_to, f_mask, f_x, f_y, f_z};
  assign {q_ctrl, q_from, q_to, q_mask, q_x, q_y, q_z} = item_rd;

  dsq_fifo #(
    .W     (ITEM_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item_wr),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (item_rd),
    .empty_o (cmd_empty)
  );

  dsq_engine #(
    .MAX_NODES (MAX_NODES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .ctrl_i      (q_ctrl),
    .from_idx_i  (q_from),
    .to_idx_i    (q_to),
    .mask_i      (q_mask),
    .set_x_i     (q_x),
    .set_y_i     (q_y),
    .set_z_i     (q_z),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_data_o  (res_bit)
  );

  dsq_fifo #(
    .W     (1),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_bit),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (separated_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

// ----- rtl/dsq_fifo.sv -----
// Small register FIFO used for the command queue and the result queue.
`default_nettype none

module dsq_fifo
  import dsq_pkg::*;
#(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dsq_front.sv -----
// Front end: decodes and checks each command, trims node sets to the nodes in use.
`default_nettype none

module dsq_front
  import dsq_pkg::*;
#(
  parameter int unsigned MAX_NODES = DSQ_MAX_NODES
) (
  input  wire logic [CMD_W-1:0]  command_i,
  input  wire logic [NODE_W-1:0] from_node_i,
  input  wire logic [NODE_W-1:0] to_node_i,
  input  wire logic [SET_W-1:0]  set_x_i,
  input  wire logic [SET_W-1:0]  set_y_i,
  input  wire logic [SET_W-1:0]  set_z_i,
  input  wire logic [NODE_W-1:0] num_nodes_i,
  output dsq_ctrl_t              ctrl_o,
  output logic [$clog2(MAX_NODES)-1:0] from_idx_o,
  output logic [$clog2(MAX_NODES)-1:0] to_idx_o,
  output logic [MAX_NODES-1:0]   mask_o,
  output logic [MAX_NODES-1:0]   set_x_o,
  output logic [MAX_NODES-1:0]   set_y_o,
  output logic [MAX_NODES-1:0]   set_z_o
);

  localparam int unsigned NW = MAX_NODES;
  localparam int unsigned IW = $clog2(MAX_NODES);

  logic [NODE_W-1:0]     count;
  logic                  edge_ok;
  logic [NW+SET_W-1:0]   x_ext, y_ext, z_ext;

  assign count = (num_nodes_i > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : num_nodes_i;

  assign edge_ok = (from_node_i != '0) && (from_node_i <= NODE_W'(MAX_NODES)) &&
                   (to_node_i != '0) && (to_node_i <= NODE_W'(MAX_NODES));

  assign from_idx_o = IW'(from_node_i - 1'b1);
  assign to_idx_o   = IW'(to_node_i - 1'b1);

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      mask_o[i] = (NODE_W'(i) < count);
    end
  end

  // sets are SET_W wide; widen or cut to the node count of the build
  assign x_ext   = {{NW{1'b0}}, set_x_i};
  assign y_ext   = {{NW{1'b0}}, set_y_i};
  assign z_ext   = {{NW{1'b0}}, set_z_i};
  assign set_x_o = x_ext[NW-1:0] & mask_o;
  assign set_y_o = y_ext[NW-1:0] & mask_o;
  assign set_z_o = z_ext[NW-1:0] & mask_o;

  always_comb begin
    ctrl_o.count = count;
    case (command_i)
      CMD_ADD:    ctrl_o.op = edge_ok ? OP_ADD : OP_NOP;
      CMD_REMOVE: ctrl_o.op = edge_ok ? OP_REMOVE : OP_NOP;
      CMD_QUERY:  ctrl_o.op = OP_QUERY;
      CMD_CLEAR:  ctrl_o.op = OP_CLEAR;
      default:    ctrl_o.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/dsq_engine.sv -----
// Back end: edge matrix, ancestor closure sweeps and Bayes-ball reachability sweeps.
`default_nettype none

module dsq_engine
  import dsq_pkg::*;
#(
  parameter int unsigned MAX_NODES = DSQ_MAX_NODES
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cmd_empty_i,
  output logic                              cmd_pop_o,
  input  wire dsq_ctrl_t                    ctrl_i,
  input  wire logic [$clog2(MAX_NODES)-1:0] from_idx_i,
  input  wire logic [$clog2(MAX_NODES)-1:0] to_idx_i,
  input  wire logic [MAX_NODES-1:0]         mask_i,
  input  wire logic [MAX_NODES-1:0]         set_x_i,
  input  wire logic [MAX_NODES-1:0]         set_y_i,
  input  wire logic [MAX_NODES-1:0]         set_z_i,
  input  wire logic                         res_full_i,
  output logic                              res_push_o,
  output logic                              res_data_o
);

  localparam int unsigned NW = MAX_NODES;
  localparam int unsigned IW = $clog2(MAX_NODES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_BALL,
    ST_RESULT
  } state_e;

  state_e            state_q, state_d;
  logic [NW-1:0]     adj_q [NW];   // row t: heads of edges t -> h
  logic [NW-1:0]     adj_d [NW];
  logic [NW-1:0]     par_q [NW];   // row h: tails of edges t -> h
  logic [NW-1:0]     par_d [NW];
  logic [IW-1:0]     idx_q, idx_d;
  logic              changed_q, changed_d;
  logic [NODE_W-1:0] count_q, count_d;
  logic [NW-1:0]     mask_q, mask_d;
  logic [NW-1:0]     x_q, x_d, y_q, y_d, z_q, z_d;
  logic [NW-1:0]     anc_z_q, anc_z_d, anc_all_q, anc_all_d;
  logic [NW-1:0]     up_q, up_d, down_q, down_d;
  logic              res_q, res_d;

  logic [NW-1:0]     row_adj, row_par;
  logic              last;

  assign row_adj = adj_q[idx_q];
  assign row_par = par_q[idx_q];
  assign last    = (NODE_W'(idx_q) == NODE_W'(count_q - 1'b1));

  assign res_data_o = res_q;

  always_comb begin
    logic [NW-1:0] pa, ch, az_n, aa_n, up_n, down_n;
    logic          chg;

    state_d   = state_q;
    adj_d     = adj_q;
    par_d     = par_q;
    idx_d     = idx_q;
    changed_d = changed_q;
    count_d   = count_q;
    mask_d    = mask_q;
    x_d       = x_q;
    y_d       = y_q;
    z_d       = z_q;
    anc_z_d   = anc_z_q;
    anc_all_d = anc_all_q;
    up_d      = up_q;
    down_d    = down_q;
    res_d     = res_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    pa     = '0;
    ch     = '0;
    az_n   = anc_z_q;
    aa_n   = anc_all_q;
    up_n   = up_q;
    down_n = down_q;
    chg    = changed_q;

    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          res_d     = 1'b0;
          state_d   = ST_RESULT;
          case (ctrl_i.op)
            OP_ADD: begin
              adj_d[from_idx_i][to_idx_i] = 1'b1;
              par_d[to_idx_i][from_idx_i] = 1'b1;
            end
            OP_REMOVE: begin
              adj_d[from_idx_i][to_idx_i] = 1'b0;
              par_d[to_idx_i][from_idx_i] = 1'b0;
            end
            OP_CLEAR: begin
              for (int i = 0; i < NW; i++) begin
                adj_d[i] = '0;
                par_d[i] = '0;
              end
            end
            OP_QUERY: begin
              count_d   = ctrl_i.count;
              mask_d    = mask_i;
              x_d       = set_x_i;
              y_d       = set_y_i;
              z_d       = set_z_i;
              anc_z_d   = set_z_i;
              anc_all_d = set_x_i | set_y_i | set_z_i;
              idx_d     = '0;
              changed_d = 1'b0;
              if (ctrl_i.count == '0) begin
                res_d = 1'b1;
              end else begin
                state_d = ST_CLOSE;
              end
            end
            default: ;
          endcase
        end
      end

      // both closures share one sweep, one node a cycle, repeated until stable
      ST_CLOSE: begin
        pa   = row_par & mask_q;
        az_n = anc_z_q | (anc_z_q[idx_q] ? pa : '0);
        aa_n = anc_all_q | (anc_all_q[idx_q] ? pa : '0);
        chg  = changed_q || (az_n != anc_z_q) || (aa_n != anc_all_q);
        anc_z_d   = az_n;
        anc_all_d = aa_n;
        if (last) begin
          idx_d     = '0;
          changed_d = 1'b0;
          if (!chg) begin
            up_d    = x_q;
            down_d  = '0;
            state_d = ST_BALL;
          end
        end else begin
          idx_d     = IW'(idx_q + 1'b1);
          changed_d = chg;
        end
      end

      ST_BALL: begin
        pa     = row_par & mask_q & anc_all_q;
        ch     = row_adj & mask_q & anc_all_q;
        up_n   = up_q;
        down_n = down_q;
        if (up_q[idx_q] && !z_q[idx_q]) begin
          up_n   = up_n | pa;
          down_n = down_n | ch;
        end
        // a self-loop may have just marked this node downward
        if (down_n[idx_q]) begin
          if (!z_q[idx_q]) begin
            down_n = down_n | ch;
          end
          if (anc_z_q[idx_q]) begin
            up_n = up_n | pa;
          end
        end
        chg    = changed_q || (up_n != up_q) || (down_n != down_q);
        up_d   = up_n;
        down_d = down_n;
        if (last) begin
          idx_d     = '0;
          changed_d = 1'b0;
          if (!chg) begin
            res_d   = (((up_n | down_n) & y_q) == '0);
            state_d = ST_RESULT;
          end
        end else begin
          idx_d     = IW'(idx_q + 1'b1);
          changed_d = chg;
        end
      end

      ST_RESULT: begin
        res_push_o = !res_full_i;
        if (!res_full_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      for (int i = 0; i < NW; i++) begin
        adj_q[i] <= '0;
        par_q[i] <= '0;
      end
      idx_q     <= '0;
      changed_q <= 1'b0;
      count_q   <= '0;
      mask_q    <= '0;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
      anc_z_q   <= '0;
      anc_all_q <= '0;
      up_q      <= '0;
      down_q    <= '0;
      res_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      adj_q     <= adj_d;
      par_q     <= par_d;
      idx_q     <= idx_d;
      changed_q <= changed_d;
      count_q   <= count_d;
      mask_q    <= mask_d;
      x_q       <= x_d;
      y_q       <= y_d;
      z_q       <= z_d;
      anc_z_q   <= anc_z_d;
      anc_all_q <= anc_all_d;
      up_q      <= up_d;
      down_q    <= down_d;
      res_q     <= res_d;
    end
  end

  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLOSE || state_q == ST_BALL) |-> (NODE_W'(idx_q) < count_q))
    else $error("node index beyond the node count");

  a_anc_nested : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLOSE || state_q == ST_BALL) |-> ((anc_z_q & ~anc_all_q) == '0))
    else $error("ancestors of Z not inside ancestors of X, Y and Z");

  a_ball_in_mask : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BALL) |-> (((up_q | down_q) & ~mask_q) == '0))
    else $error("ball reached a node outside the count");

  a_ball_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BALL && $past(state_q) == ST_BALL) |->
      (($past(up_q) & ~up_q) == '0 && ($past(down_q) & ~down_q) == '0))
    else $error("visited sets shrank during a sweep");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (!res_full_i && state_q == ST_RESULT))
    else $error("result beat pushed without room");

endmodule

`default_nettype wire
